// ===== rtl/kwc_pkg.sv =====
// Shared types and constants for the keyword substitution cipher.
`default_nettype none

package kwc_pkg;

   localparam int unsigned ALPHABET_SIZE = 26;
   localparam int unsigned IDX_W         = $clog2(ALPHABET_SIZE);
   localparam int unsigned CHAR_W        = 8;

   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ALPHABET_SIZE - 1);
   localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(ALPHABET_SIZE);

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_KEY     = 2'd1,
      OP_FINISH  = 2'd2,
      OP_ENCRYPT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FINISH,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic             is_lower;
      logic             is_upper;
      logic [IDX_W-1:0] idx;
   } char_class_type;

endpackage

`default_nettype wire

// ===== rtl/keyword_substitution_cipher_top.sv =====
// Top level of the keyword substitution cipher: sequencer, key state and output register.
`default_nettype none

// Keyword cipher. Requests carry an operation and a byte: start clears the key, a key
// byte (either case) appends its letter to the substitution table if not yet present,
// finish appends all unused letters in a-to-z order, and encrypt maps a letter through
// the table keeping its case while other bytes pass unchanged. Only encrypt returns a
// response. Encrypt reads the 26-entry table, a RAM with a registered read, and
// waits in a lookup state while an earlier response is still held. Finish walks the
// 26 letters with one shared append unit, one per cycle. Encrypting before finish
// reads table entries that may hold stale letters.
module keyword_substitution_cipher_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out
);

   localparam int unsigned IW = kwc_pkg::IDX_W;
   localparam int unsigned AS = kwc_pkg::ALPHABET_SIZE;

   kwc_pkg::state_type       state_ff, state_in;
   logic [AS-1:0]            seen_ff, seen_in;
   logic [IW-1:0]            fill_ff, fill_in;
   logic [IW-1:0]            walk_ff, walk_in;
   logic [7:0]               char_ff, char_in;
   kwc_pkg::char_class_type  class_ff, class_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff, rsp_char_in;

   kwc_pkg::char_class_type  req_class;
   kwc_pkg::op_type          op;
   logic                     req_accept;
   logic                     append_req;
   logic                     append_ok;
   logic [IW-1:0]            append_idx;
   logic                     rd_en;
   logic [IW-1:0]            rd_data;

   kwc_classify u_classify (
      .char_in    (req_char_in),
      .char_class (req_class)
   );

   kwc_ram #(
      .WIDTH (IW),
      .DEPTH (AS)
   ) u_table (
      .clock   (clock),
      .wr_en   (append_ok),
      .wr_addr (fill_ff),
      .wr_data (append_idx),
      .rd_en   (rd_en),
      .rd_addr (req_class.idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwc_pkg::ST_IDLE;
         seen_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      char_ff     <= char_in;
      class_ff    <= class_in;
      rsp_char_ff <= rsp_char_in;
   end

   always_comb begin
      req_ready  = (state_ff == kwc_pkg::ST_IDLE);
      req_accept = req_valid && req_ready;
      op         = kwc_pkg::op_type'(req_operation);

      state_in     = state_ff;
      seen_in      = seen_ff;
      fill_in      = fill_ff;
      walk_in      = walk_ff;
      char_in      = char_ff;
      class_in     = class_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      append_req   = 1'b0;
      rd_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // The append unit is shared by key letters and the finish walk.
      append_idx = (state_ff == kwc_pkg::ST_FINISH) ? walk_ff : req_class.idx;

      case (state_ff)
         kwc_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (op)
                  kwc_pkg::OP_START: begin
                     seen_in = '0;
                     fill_in = '0;
                  end
                  kwc_pkg::OP_KEY: begin
                     append_req = req_class.is_lower || req_class.is_upper;
                  end
                  kwc_pkg::OP_FINISH: begin
                     walk_in  = '0;
                     state_in = kwc_pkg::ST_FINISH;
                  end
                  kwc_pkg::OP_ENCRYPT: begin
                     rd_en    = 1'b1;
                     char_in  = req_char_in;
                     class_in = req_class;
                     state_in = kwc_pkg::ST_LOOKUP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kwc_pkg::ST_FINISH: begin
            append_req = 1'b1;
            walk_in    = walk_ff + IW'(1);
            if (walk_ff == kwc_pkg::LAST_IDX) begin
               state_in = kwc_pkg::ST_IDLE;
            end
         end
         kwc_pkg::ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (class_ff.is_lower) begin
                  rsp_char_in = kwc_pkg::CHAR_LOWER_A + {{(8 - IW){1'b0}}, rd_data};
               end else if (class_ff.is_upper) begin
                  rsp_char_in = kwc_pkg::CHAR_UPPER_A + {{(8 - IW){1'b0}}, rd_data};
               end else begin
                  rsp_char_in = char_ff;
               end
               state_in = kwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kwc_pkg::ST_IDLE;
         end
      endcase

      append_ok = append_req && !seen_ff[append_idx] && (fill_ff < kwc_pkg::FULL_COUNT);
      if (append_ok) begin
         seen_in[append_idx] = 1'b1;
         fill_in             = fill_ff + IW'(1);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;

endmodule

`default_nettype wire

// ===== rtl/kwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kwc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/kwc_classify.sv =====
// Letter classifier: detects lower and upper case letters and gives their alphabet index.
`default_nettype none

module kwc_classify (
   input  wire logic [kwc_pkg::CHAR_W-1:0] char_in,
   output kwc_pkg::char_class_type         char_class
);

   logic                        is_lower;
   logic                        is_upper;
   logic [kwc_pkg::CHAR_W-1:0]  offset;

   always_comb begin
      is_lower = (char_in >= kwc_pkg::CHAR_LOWER_A) && (char_in <= kwc_pkg::CHAR_LOWER_Z);
      is_upper = (char_in >= kwc_pkg::CHAR_UPPER_A) && (char_in <= kwc_pkg::CHAR_UPPER_Z);
      if (is_lower) begin
         offset = char_in - kwc_pkg::CHAR_LOWER_A;
      end else if (is_upper) begin
         offset = char_in - kwc_pkg::CHAR_UPPER_A;
      end else begin
         offset = '0;
      end
      char_class.is_lower = is_lower;
      char_class.is_upper = is_upper;
      char_class.idx      = offset[kwc_pkg::IDX_W-1:0];
   end

endmodule

`default_nettype wire

// ===== verif/keyword_substitution_cipher_top_tb.sv =====
// Testbench for the keyword substitution cipher: directed and random requests checked by a predictor.
module keyword_substitution_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ALPHABET_SIZE = kwc_pkg::ALPHABET_SIZE;
   localparam int unsigned IDX_W         = kwc_pkg::IDX_W;

   localparam int TOTAL_REQUESTS = 1900;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation = kwc_pkg::OP_START;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;

   // Predicted key state.
   logic [ALPHABET_SIZE-1:0] seen_letters = '0;
   logic [IDX_W-1:0]         subst_map [ALPHABET_SIZE];
   logic [IDX_W-1:0]         fill_level = '0;

   logic [7:0] char_out_expected [$];
   int         mismatch_count = 0;
   int         requests_sent = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         stall_cycle = 0;
   int         stall_mode = 0;

   keyword_substitution_cipher_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void append_letter(input logic [IDX_W-1:0] idx);
      if (!seen_letters[idx] && fill_level < ALPHABET_SIZE) begin
         subst_map[fill_level] = idx;
         seen_letters[idx]     = 1'b1;
         fill_level            = fill_level + 1'b1;
      end
   endfunction

   // Updates the key state for one accepted request and queues the ciphertext of an encrypt.
   function automatic void predict_cipher(input kwc_pkg::op_type op, input logic [7:0] ch);
      logic [7:0] result;
      result = ch;
      case (op)
         kwc_pkg::OP_START: begin
            seen_letters = '0;
            fill_level   = '0;
         end
         kwc_pkg::OP_KEY: begin
            if (ch >= kwc_pkg::CHAR_UPPER_A && ch <= kwc_pkg::CHAR_UPPER_Z)
               append_letter(IDX_W'(ch - kwc_pkg::CHAR_UPPER_A));
            else if (ch >= kwc_pkg::CHAR_LOWER_A && ch <= kwc_pkg::CHAR_LOWER_Z)
               append_letter(IDX_W'(ch - kwc_pkg::CHAR_LOWER_A));
         end
         kwc_pkg::OP_FINISH: begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
               append_letter(IDX_W'(i));
         end
         default: begin
            if (ch >= kwc_pkg::CHAR_LOWER_A && ch <= kwc_pkg::CHAR_LOWER_Z)
               result = kwc_pkg::CHAR_LOWER_A + 8'(subst_map[ch - kwc_pkg::CHAR_LOWER_A]);
            else if (ch >= kwc_pkg::CHAR_UPPER_A && ch <= kwc_pkg::CHAR_UPPER_Z)
               result = kwc_pkg::CHAR_UPPER_A + 8'(subst_map[ch - kwc_pkg::CHAR_UPPER_A]);
            char_out_expected = {char_out_expected, result};
         end
      endcase
   endfunction

   // Presents one request, inserting a random gap at the start of each burst.
   task automatic send_request(input kwc_pkg::op_type op, input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_char_in   <= ch;
      do @(posedge clock); while (!req_ready);
      predict_cipher(op, ch);
      requests_sent++;
   endtask

   function automatic logic [7:0] random_text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return kwc_pkg::CHAR_LOWER_A + 8'($urandom_range(0, ALPHABET_SIZE - 1));
         4, 5, 6:    return kwc_pkg::CHAR_UPPER_A + 8'($urandom_range(0, ALPHABET_SIZE - 1));
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Only non-letters are encrypted here: no table entry has been written yet.
   task automatic test_passthrough_after_reset();
      send_request(kwc_pkg::OP_ENCRYPT, 8'h00);
      send_request(kwc_pkg::OP_ENCRYPT, 8'hFF);
      send_request(kwc_pkg::OP_ENCRYPT, 8'h40);
      send_request(kwc_pkg::OP_ENCRYPT, 8'h7B);
   endtask

   task automatic test_key_folding();
      send_request(kwc_pkg::OP_START, 8'hFF);
      send_request(kwc_pkg::OP_KEY, "Z");
      send_request(kwc_pkg::OP_KEY, "z");
      send_request(kwc_pkg::OP_KEY, "9");
      send_request(kwc_pkg::OP_KEY, 8'hFF);
      send_request(kwc_pkg::OP_KEY, "a");
      send_request(kwc_pkg::OP_FINISH, 8'h00);
      send_request(kwc_pkg::OP_ENCRYPT, "a");
      send_request(kwc_pkg::OP_ENCRYPT, "z");
      send_request(kwc_pkg::OP_ENCRYPT, "A");
      send_request(kwc_pkg::OP_ENCRYPT, "Z");
   endtask

   task automatic test_finish_repeat();
      send_request(kwc_pkg::OP_FINISH, 8'h55);
      send_request(kwc_pkg::OP_KEY, "q");
      send_request(kwc_pkg::OP_ENCRYPT, "q");
   endtask

   // A new key that is not finished leaves the upper entries holding the old letters.
   task automatic test_stale_table();
      send_request(kwc_pkg::OP_START, 8'h00);
      send_request(kwc_pkg::OP_KEY, "M");
      send_request(kwc_pkg::OP_ENCRYPT, "a");
      send_request(kwc_pkg::OP_ENCRYPT, "b");
      send_request(kwc_pkg::OP_ENCRYPT, "Y");
   endtask

   task automatic test_random_traffic();
      int key_len;
      int run_len;
      while (requests_sent < TOTAL_REQUESTS) begin
         if ($urandom_range(0, 9) < 8) begin
            send_request(kwc_pkg::OP_START, 8'($urandom_range(0, 255)));
            key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 40)
                                                  : $urandom_range(0, 12);
            repeat (key_len) begin
               if ($urandom_range(0, 9) == 0)
                  send_request(kwc_pkg::OP_KEY, 8'($urandom_range(0, 255)));
               else
                  send_request(kwc_pkg::OP_KEY, random_text_byte());
            end
            send_request(kwc_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
            run_len = $urandom_range(1, 30);
            repeat (run_len) send_request(kwc_pkg::OP_ENCRYPT, random_text_byte());
         end else begin
            run_len = $urandom_range(1, 20);
            repeat (run_len)
               send_request(kwc_pkg::op_type'($urandom_range(0, 3)), random_text_byte());
         end
      end
   endtask

   // The receiver switches between randomly chosen stall behaviors.
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 97 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_cycle % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (char_out_expected.size() == 0) begin
               $error("char_out: expected no response, got %h", rsp_char_out);
               mismatch_count++;
            end else if (rsp_char_out !== char_out_expected[0]) begin
               $error("char_out: expected %h, got %h", char_out_expected[0], rsp_char_out);
               mismatch_count++;
               void'(char_out_expected.pop_front());
            end else begin
               void'(char_out_expected.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_passthrough_after_reset();
      test_key_folding();
      test_finish_repeat();
      test_stale_table();
      test_random_traffic();
      req_valid <= 1'b0;
      while (char_out_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/kwc_pkg.sv
rtl/kwc_ram.sv
rtl/kwc_classify.sv
rtl/keyword_substitution_cipher_top.sv
verif/keyword_substitution_cipher_top_tb.sv
